// File: rtl/vfsgf_pkg.sv
// Package for the voice frame sequence gap filler.
// Holds widths, limits, the result kind codes and the command record that
// passes from the front classifier to the back sequencer. No dependencies.
package vfsgf_pkg;

    localparam int SEQ_W        = 5;   // sequence number width
    localparam int SEQ_MODULUS  = 21;  // default sequence count
    localparam int MAX_RESULTS  = 19;  // most results any item may cause
    localparam int GAP_LIMIT    = MAX_RESULTS - 1;
    localparam int CFG_W        = 5;   // width of each config register
    localparam int QUEUE_DEPTH  = 4;   // command queue entries, power of two
    localparam int END_BIT      = 6;   // end marker position in the sequence byte

    localparam logic [CFG_W-1:0] SILENCE_GAP_RESET = 5'd2;
    localparam logic [CFG_W-1:0] MAX_GAP_RESET     = 5'd18;

    // Register indexes (byte address is 4 * index)
    localparam logic REG_SILENCE_GAP = 1'b0;
    localparam logic REG_MAX_GAP     = 1'b1;

    typedef enum logic [2:0] {
        KIND_FRAME   = 3'd0,
        KIND_REPEAT  = 3'd1,
        KIND_SILENCE = 3'd2,
        KIND_END     = 3'd3,
        KIND_NONE    = 3'd4
    } frame_kind_t;

    // run = 0: one result of the given kind at seq, last set.
    // run = 1: gap fillers of the given kind from seq on, then the frame.
    typedef struct packed {
        logic             run;
        frame_kind_t      kind;
        logic [SEQ_W-1:0] gap;
        logic [SEQ_W-1:0] seq;
    } cmd_t;

endpackage

// File: rtl/vfsgf_front.sv
// Front classifier of the voice frame sequence gap filler.
// Takes input transfers, keeps the expected sequence number and pushes one
// command per item into the queue. Depends on vfsgf_pkg.
module vfsgf_front #(
    parameter int SEQ_MODULUS = vfsgf_pkg::SEQ_MODULUS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [15:0]                   s_tdata,
    input  logic                          s_tuser,
    input  logic [vfsgf_pkg::CFG_W-1:0]   silence_gap,
    input  logic [vfsgf_pkg::CFG_W-1:0]   max_gap,
    input  logic                          queue_full,
    output logic                          push,
    output vfsgf_pkg::cmd_t               cmd
);

    localparam int SW = vfsgf_pkg::SEQ_W;

    logic [SW-1:0]  expected_seq_reg;
    logic [SW-1:0]  expected_seq_next;
    logic [7:0]     seq_byte;
    logic           disabled;
    logic           action;
    logic [SW-1:0]  seq_num;
    logic [SW+1:0]  gap_wide;
    logic [SW-1:0]  gap;
    logic [SW-1:0]  limit;
    logic [SW:0]    seq_inc;

    assign seq_byte = s_tdata[7:0];
    assign disabled = s_tdata[8];
    assign action   = s_tuser;
    assign seq_num  = seq_byte[SW-1:0];

    assign s_tready = !queue_full;
    assign push     = s_tvalid && s_tready;

    // Distance from the expected slot to the received one, modulo the count
    always_comb begin
        if (seq_num >= expected_seq_reg) begin
            gap_wide = {2'b00, seq_num} - {2'b00, expected_seq_reg};
        end else begin
            gap_wide = {2'b00, seq_num} + (SW+2)'(SEQ_MODULUS) - {2'b00, expected_seq_reg};
        end
    end
    assign gap = gap_wide[SW-1:0];

    assign limit   = (max_gap > SW'(vfsgf_pkg::GAP_LIMIT)) ? SW'(vfsgf_pkg::GAP_LIMIT) : max_gap;
    assign seq_inc = {1'b0, seq_num} + (SW+1)'(1);

    always_comb begin
        cmd.run           = 1'b0;
        cmd.kind          = vfsgf_pkg::KIND_NONE;
        cmd.gap           = '0;
        cmd.seq           = expected_seq_reg;
        expected_seq_next = expected_seq_reg;
        if (disabled) begin
            // keep state, queue a result of kind none
        end else if (!action) begin
            cmd.seq           = '0;
            expected_seq_next = '0;
        end else if (seq_byte[vfsgf_pkg::END_BIT]) begin
            cmd.kind = vfsgf_pkg::KIND_END;
        end else if ({1'b0, seq_num} >= (SW+1)'(SEQ_MODULUS)) begin
            // out of range: drop
        end else if (gap > limit) begin
            // stale: drop
        end else begin
            cmd.run  = 1'b1;
            cmd.kind = (gap > silence_gap) ? vfsgf_pkg::KIND_SILENCE
                                           : vfsgf_pkg::KIND_REPEAT;
            cmd.gap  = gap;
            if (seq_inc == (SW+1)'(SEQ_MODULUS)) begin
                expected_seq_next = '0;
            end else begin
                expected_seq_next = seq_inc[SW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expected_seq_reg <= '0;
        end else if (push) begin
            expected_seq_reg <= expected_seq_next;
        end
    end

endmodule

// File: rtl/vfsgf_queue.sv
// Command queue between front and back of the gap filler.
// Small register FIFO of cmd_t records. Depends on vfsgf_pkg.
module vfsgf_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  vfsgf_pkg::cmd_t din,
    output logic            full,
    input  logic            pop,
    output vfsgf_pkg::cmd_t dout,
    output logic            empty
);

    localparam int DEPTH = vfsgf_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    vfsgf_pkg::cmd_t   entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_push;
    logic              do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

// File: rtl/vfsgf_back.sv
// Back sequencer of the voice frame sequence gap filler.
// Takes commands from the queue and, unless the output stalls, emits result
// transfers one per cycle through an output register. Depends on vfsgf_pkg.
module vfsgf_back #(
    parameter int SEQ_MODULUS = vfsgf_pkg::SEQ_MODULUS
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        queue_empty,
    input  vfsgf_pkg::cmd_t             cmd,
    output logic                        pop,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [7:0]                  m_tdata,
    output logic [3:0]                  m_tuser,
    output logic                        m_tlast
);

    localparam int SW = vfsgf_pkg::SEQ_W;

    logic                   busy_reg;
    logic                   run_reg;
    vfsgf_pkg::frame_kind_t kind_reg;
    logic [SW-1:0]          remain_reg;
    logic [SW-1:0]          cur_seq_reg;
    logic                   out_valid_reg;
    vfsgf_pkg::frame_kind_t out_kind_reg;
    logic                   out_sync_reg;
    logic [SW-1:0]          out_seq_reg;
    logic                   out_last_reg;
    logic                   slot_free;
    logic                   emit;
    logic [SW:0]            seq_inc;
    logic [SW-1:0]          seq_step;

    assign slot_free = !out_valid_reg || m_tready;
    assign emit      = busy_reg && slot_free;
    assign pop       = !busy_reg && !queue_empty;

    assign seq_inc  = {1'b0, cur_seq_reg} + (SW+1)'(1);
    assign seq_step = (seq_inc == (SW+1)'(SEQ_MODULUS)) ? '0 : seq_inc[SW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                busy_reg <= 1'b1;
            end else if (emit && (!run_reg || remain_reg == '0)) begin
                busy_reg <= 1'b0;
            end
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            run_reg     <= cmd.run;
            kind_reg    <= cmd.kind;
            remain_reg  <= cmd.gap;
            cur_seq_reg <= cmd.seq;
        end else if (emit && run_reg && remain_reg != '0) begin
            remain_reg  <= remain_reg - SW'(1);
            cur_seq_reg <= seq_step;
        end
        if (emit) begin
            out_seq_reg <= cur_seq_reg;
            if (!run_reg) begin
                out_kind_reg <= kind_reg;
                out_sync_reg <= 1'b0;
                out_last_reg <= 1'b1;
            end else if (remain_reg != '0) begin
                out_kind_reg <= kind_reg;
                out_sync_reg <= (cur_seq_reg == '0);
                out_last_reg <= 1'b0;
            end else begin
                out_kind_reg <= vfsgf_pkg::KIND_FRAME;
                out_sync_reg <= (cur_seq_reg == '0);
                out_last_reg <= 1'b1;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(8-SW){1'b0}}, out_seq_reg};
    assign m_tuser  = {out_sync_reg, out_kind_reg};
    assign m_tlast  = out_last_reg;

endmodule

// File: rtl/voice_frame_sequence_gap_filler_unit.sv
// Top level of the voice frame sequence gap filler.
// Instantiates vfsgf_front, vfsgf_queue and vfsgf_back, and holds the
// configuration registers. Depends on vfsgf_pkg.

// Each input transfer is a stream header or a data frame with a raw sequence
// byte. The block tracks the next expected sequence number (counting modulo
// SEQ_MODULUS) and, for an in-window data frame, emits one filler transfer
// per missing slot (repeat of the last frame, or silence when the gap is
// above silence_gap) followed by the frame itself; headers, disabled
// items, end markers, out-of-range and stale frames yield one transfer.
// m_tlast marks the final result of each item. The back sequencer loads a
// command and then emits its results one per cycle while the output is not
// stalled, loading the next only after the last result; it sets the rate,
// while the front classifies an item per cycle into a four-entry command
// queue and keeps taking items as long as that queue has room.
// Registers: 0x0 silence_gap (reset 2), 0x4 max_gap (reset 18,
// limited internally to 18); write them only while the block is idle.
module voice_frame_sequence_gap_filler_unit #(
    parameter int SEQ_MODULUS = vfsgf_pkg::SEQ_MODULUS
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] seq_byte, [8] disabled, rest zero
    input  logic        s_tuser,   // [0] action
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [4:0] frame_seq, rest zero
    output logic [3:0]  m_tuser,   // [2:0] frame_kind, [3] add_sync
    output logic        m_tlast,   // last
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CW = vfsgf_pkg::CFG_W;
    localparam int SW = vfsgf_pkg::SEQ_W;

    logic [CW-1:0]   silence_gap_reg;
    logic [CW-1:0]   max_gap_reg;
    logic            cfg_write;
    logic            push;
    logic            pop;
    logic            queue_full;
    logic            queue_empty;
    vfsgf_pkg::cmd_t front_cmd;
    vfsgf_pkg::cmd_t back_cmd;

    // Configuration port: always ready, register chosen by address bit 2
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            silence_gap_reg <= vfsgf_pkg::SILENCE_GAP_RESET;
            max_gap_reg     <= vfsgf_pkg::MAX_GAP_RESET;
        end else if (cfg_write) begin
            case (paddr[2])
                vfsgf_pkg::REG_SILENCE_GAP: silence_gap_reg <= pwdata[CW-1:0];
                vfsgf_pkg::REG_MAX_GAP:     max_gap_reg     <= pwdata[CW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            vfsgf_pkg::REG_SILENCE_GAP: prdata = {{(32-CW){1'b0}}, silence_gap_reg};
            vfsgf_pkg::REG_MAX_GAP:     prdata = {{(32-CW){1'b0}}, max_gap_reg};
            default:                    prdata = '0;
        endcase
    end

    // Front: classify each item and advance the expected sequence number
    vfsgf_front #(
        .SEQ_MODULUS(SEQ_MODULUS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .silence_gap (silence_gap_reg),
        .max_gap     (max_gap_reg),
        .queue_full  (queue_full),
        .push        (push),
        .cmd         (front_cmd)
    );

    // Queue: decouple classification from result generation
    vfsgf_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .din     (front_cmd),
        .full    (queue_full),
        .pop     (pop),
        .dout    (back_cmd),
        .empty   (queue_empty)
    );

    // Back: expand commands into result transfers
    vfsgf_back #(
        .SEQ_MODULUS(SEQ_MODULUS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .queue_empty (queue_empty),
        .cmd         (back_cmd),
        .pop         (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

`ifndef SYNTHESIS
    // A full queue must hold off the input side
    a_full_stalls_input: assert property (@(posedge aclk) disable iff (!aresetn)
        queue_full |-> !s_tready)
        else $error("input accepted while command queue full");

    // Every emitted slot lies inside the sequence count
    a_seq_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ({1'b0, m_tdata[SW-1:0]} < (SW+1)'(SEQ_MODULUS)))
        else $error("frame_seq outside sequence count");

    // Sync flag only on slot zero
    a_sync_slot_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[3]) |-> (m_tdata[SW-1:0] == '0))
        else $error("add_sync set outside slot zero");

    // Single-result kinds and incoming frames always close the item
    a_last_on_closing_kinds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser[2:0] == vfsgf_pkg::KIND_NONE
                      || m_tuser[2:0] == vfsgf_pkg::KIND_END
                      || m_tuser[2:0] == vfsgf_pkg::KIND_FRAME)) |-> m_tlast)
        else $error("closing result without last");

    // Fillers never close an item
    a_filler_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser[2:0] == vfsgf_pkg::KIND_REPEAT
                      || m_tuser[2:0] == vfsgf_pkg::KIND_SILENCE)) |-> !m_tlast)
        else $error("filler result marked last");
`endif

endmodule

// File: verif/voice_frame_sequence_gap_filler_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for voice_frame_sequence_gap_filler_unit: streams headers and
// frames, predicts the gap-fill results and checks every result transfer.
// Depends on vfsgf_pkg and the unit's RTL.
module voice_frame_sequence_gap_filler_unit_tb;

    localparam int CYCLE_LIMIT   = 400000;  // far above the slowest correct run
    localparam int SEGMENTS      = 8;       // segment 0 is directed, the rest random
    localparam int ITEMS_PER_SEG = 52;      // counted items per random segment
    localparam int DRAIN_CYCLES  = 30;      // quiet time after the last result

    typedef struct {
        logic       action;
        logic [7:0] sbyte;
        logic       off;
    } vf_item_t;

    typedef struct {
        vfsgf_pkg::frame_kind_t kind;
        logic                   sync;
        logic [4:0]             slot;
        logic                   last;
    } vf_frame_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;   // [7:0] seq_byte, [8] disabled, rest zero
    logic        s_tuser  = 1'b0; // [0] action
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;         // [4:0] frame_seq, rest zero
    logic [3:0]  m_tuser;         // [2:0] frame_kind, [3] add_sync
    logic        m_tlast;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    vf_item_t  pending_items[$];   // items waiting for the driver
    vf_frame_t due_frames[$];      // results predicted but not yet seen
    vf_item_t  drv_item;

    // Predictor state and its copy of the registers
    logic [4:0] slot_expected = '0;
    logic [4:0] sil_cfg       = vfsgf_pkg::SILENCE_GAP_RESET;
    logic [4:0] max_gap_cfg   = vfsgf_pkg::MAX_GAP_RESET;

    int send_idle_pct = 23;
    int recv_idle_pct = 51;
    int mismatches    = 0;
    int cycles        = 0;

    voice_frame_sequence_gap_filler_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("ERROR @%0t: %s", $time, msg);
    endtask

    function automatic logic [4:0] slot_after(input logic [4:0] slot);
        return (slot == vfsgf_pkg::SEQ_MODULUS - 1) ? 5'd0 : slot + 5'd1;
    endfunction

    function automatic void push_frame(input vfsgf_pkg::frame_kind_t kind, input logic sync,
                                       input logic [4:0] slot, input logic last);
        vf_frame_t f;
        f.kind = kind;
        f.sync = sync;
        f.slot = slot;
        f.last = last;
        due_frames.push_back(f);
    endfunction

    // Work out every result that one accepted item causes and advance the
    // expected slot as the unit does.
    task automatic predict_frames(input logic action, input logic [7:0] sbyte,
                                  input logic off);
        int                     num;
        int                     gap;
        int                     lim;
        vfsgf_pkg::frame_kind_t fill;
        num = int'(sbyte[4:0]);
        if (off) begin
            push_frame(vfsgf_pkg::KIND_NONE, 1'b0, slot_expected, 1'b1);
        end else if (!action) begin
            // header restarts the sequence
            slot_expected = '0;
            push_frame(vfsgf_pkg::KIND_NONE, 1'b0, 5'd0, 1'b1);
        end else if (sbyte[vfsgf_pkg::END_BIT]) begin
            push_frame(vfsgf_pkg::KIND_END, 1'b0, slot_expected, 1'b1);
        end else if (num >= vfsgf_pkg::SEQ_MODULUS) begin
            push_frame(vfsgf_pkg::KIND_NONE, 1'b0, slot_expected, 1'b1);
        end else begin
            gap = num - int'(slot_expected);
            if (gap < 0) begin
                gap += vfsgf_pkg::SEQ_MODULUS;
            end
            // the gap limit saturates so no item exceeds the result budget
            lim = (int'(max_gap_cfg) > vfsgf_pkg::GAP_LIMIT) ? vfsgf_pkg::GAP_LIMIT
                                                              : int'(max_gap_cfg);
            if (gap > lim) begin
                // stale frame: drop it, keep the state
                push_frame(vfsgf_pkg::KIND_NONE, 1'b0, slot_expected, 1'b1);
            end else begin
                fill = (gap > int'(sil_cfg)) ? vfsgf_pkg::KIND_SILENCE
                                             : vfsgf_pkg::KIND_REPEAT;
                repeat (gap) begin
                    push_frame(fill, slot_expected == 5'd0, slot_expected, 1'b0);
                    slot_expected = slot_after(slot_expected);
                end
                push_frame(vfsgf_pkg::KIND_FRAME, slot_expected == 5'd0, slot_expected, 1'b1);
                slot_expected = slot_after(slot_expected);
            end
        end
    endtask

    // Driver: advance to the next queued item once the current transfer is
    // taken, idling at random per the current mode.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                drv_item = pending_items.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {7'b0, drv_item.off, drv_item.sbyte};
                s_tuser  <= drv_item.action;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: predict on each input transfer, check each result transfer
    // against the oldest prediction, and stall the result side at random.
    always @(posedge aclk) begin
        vf_frame_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
            if (s_tvalid && s_tready) begin
                predict_frames(s_tuser, s_tdata[7:0], s_tdata[8]);
            end
            if (m_tvalid && m_tready) begin
                if (due_frames.size() == 0) begin
                    report_mismatch($sformatf("unexpected result kind=%0d seq=%0d",
                                              m_tuser[2:0], m_tdata[4:0]));
                end else begin
                    want = due_frames.pop_front();
                    if (m_tuser[2:0] !== want.kind || m_tuser[3] !== want.sync ||
                        m_tdata[4:0] !== want.slot || m_tlast !== want.last) begin
                        report_mismatch($sformatf(
                            "got kind=%0d sync=%0b seq=%0d last=%0b, want %0d %0b %0d %0b",
                            m_tuser[2:0], m_tuser[3], m_tdata[4:0], m_tlast,
                            want.kind, want.sync, want.slot, want.last));
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic add_item(input logic action, input logic [7:0] sbyte, input logic off);
        vf_item_t it;
        it.action = action;
        it.sbyte  = sbyte;
        it.off    = off;
        pending_items.push_back(it);
    endtask

    // Hold until the driver is empty and every predicted result has arrived.
    task automatic settle();
        @(negedge aclk);
        while (pending_items.size() != 0 || s_tvalid || due_frames.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    // Setup cycle, then access cycle; the register takes the value at the
    // edge that ends the access cycle.
    task automatic write_reg(input logic idx, input logic [4:0] val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {27'b0, val};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == vfsgf_pkg::REG_SILENCE_GAP) begin
            sil_cfg = val;
        end else begin
            max_gap_cfg = val;
        end
    endtask

    // Directed items, meant for the reset settings (threshold 2, gap limit 18).
    task automatic directed_items();
        add_item(1'b0, 8'h00, 1'b0);   // header
        add_item(1'b1, 8'h00, 1'b0);   // slot zero carries sync
        add_item(1'b1, 8'h01, 1'b0);
        add_item(1'b1, 8'h04, 1'b0);   // gap at threshold: repeats
        add_item(1'b1, 8'h08, 1'b0);   // gap above threshold: silence
        add_item(1'b1, 8'h40, 1'b0);   // end marker
        add_item(1'b1, 8'hFF, 1'b0);   // end marker with all bits set
        add_item(1'b1, 8'hFF, 1'b1);   // disabled frame
        add_item(1'b0, 8'h00, 1'b1);   // disabled header
        add_item(1'b1, 8'h15, 1'b0);   // smallest number out of range
        add_item(1'b1, 8'h1F, 1'b0);   // largest number out of range
        add_item(1'b1, 8'hA9, 1'b0);   // ignored upper bits set
        add_item(1'b1, 8'h14, 1'b0);   // silence up to the last slot
        add_item(1'b1, 8'h00, 1'b0);   // wrap to slot zero
        add_item(1'b1, 8'h13, 1'b0);   // widest gap still accepted
        add_item(1'b1, 8'h12, 1'b0);   // gap one past the limit: stale
        add_item(1'b1, 8'h14, 1'b0);
        add_item(1'b1, 8'h13, 1'b0);   // stale across the wrap
        add_item(1'b0, 8'hFF, 1'b0);   // header with a noisy byte
        add_item(1'b1, 8'h80, 1'b0);
    endtask

    // Mostly in-order frames with random content, plus jumps, headers, end
    // markers, disabled and malformed items. Disabled items are not counted.
    task automatic random_items(input int count, input int start_slot);
        int         made;
        int         pick;
        int         gen_slot;
        logic [7:0] junk;
        made     = 0;
        gen_slot = start_slot;
        while (made < count) begin
            pick = $urandom_range(99);
            junk = 8'($urandom_range(255));
            made++;
            if (pick < 55) begin
                add_item(1'b1, {junk[7], 1'b0, junk[5], 5'(gen_slot)}, 1'b0);
                gen_slot = (gen_slot + 1) % vfsgf_pkg::SEQ_MODULUS;
            end else if (pick < 70) begin
                gen_slot = (gen_slot + $urandom_range(20, 1)) % vfsgf_pkg::SEQ_MODULUS;
                add_item(1'b1, {junk[7], 1'b0, junk[5], 5'(gen_slot)}, 1'b0);
                gen_slot = (gen_slot + 1) % vfsgf_pkg::SEQ_MODULUS;
            end else if (pick < 77) begin
                add_item(1'b0, junk, 1'b0);
                gen_slot = 0;
            end else if (pick < 84) begin
                add_item(1'b1, junk | 8'h40, 1'b0);
            end else if (pick < 89) begin
                add_item(junk[0], 8'($urandom_range(255)), 1'b1);
                made--;
            end else if (pick < 94) begin
                add_item(1'b1, {junk[7], 1'b0, junk[5], 5'($urandom_range(31, 21))}, 1'b0);
            end else begin
                add_item(1'($urandom_range(1)), junk, 1'b0);
            end
        end
    endtask

    initial begin
        logic [4:0] sil_plan [SEGMENTS];
        logic [4:0] gap_plan [SEGMENTS];
        sil_plan = '{5'd2, 5'd0, 5'd20, 5'd3, 5'd0, 5'd20, 5'd0, 5'd0};
        gap_plan = '{5'd18, 5'd20, 5'd0, 5'd18, 5'd0, 5'd20, 5'd5, 5'd0};
        sil_plan[4] = 5'($urandom_range(20));
        gap_plan[4] = 5'($urandom_range(20));
        sil_plan[7] = 5'($urandom_range(20));
        gap_plan[7] = 5'($urandom_range(20));

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            // Drain before touching registers; this also pauses the sender
            // until every predicted result has come back.
            settle();
            if (seg != 0) begin
                write_reg(vfsgf_pkg::REG_SILENCE_GAP, sil_plan[seg]);
                write_reg(vfsgf_pkg::REG_MAX_GAP, gap_plan[seg]);
            end
            @(negedge aclk);
            // Sender lightly idle first, then the receiver lightly idle,
            // then both at full rate.
            if (seg < 3) begin
                send_idle_pct = 23;
                recv_idle_pct = 51;
            end else if (seg < 6) begin
                send_idle_pct = 51;
                recv_idle_pct = 23;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (seg == 0) begin
                directed_items();
            end else begin
                random_items(ITEMS_PER_SEG, int'(slot_expected));
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
